@@ rtl/core/smcq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smcq_pkg: shared constants and types for the subarray max count query block
// Sizes, FSM state encoding and the controller/datapath command and status.
// ----------------------------------------------------------------------------
package smcq_pkg;

  localparam int MAX_ELEMS = 1024;
  localparam int IDX_W     = $clog2(MAX_ELEMS);
  localparam int CNT_W     = IDX_W + 1;
  localparam int VAL_W     = 32;
  localparam int SUM_W     = 20;
  localparam int PROD_W    = 2 * CNT_W;
  localparam int ACC_W     = ((PROD_W > SUM_W) ? PROD_W : SUM_W) + 1;
  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam logic DIR_LEFT  = 1'b0;
  localparam logic DIR_RIGHT = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT_L,
    ST_INIT_R,
    ST_FETCH,
    ST_CHECK,
    ST_TOP,
    ST_SCAN_INIT,
    ST_SCAN,
    ST_DRAIN,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic load;         // store accepted load beat
    logic capture_q;    // latch query value
    logic pass_start;   // start a stack pass
    logic pass_dir;     // direction for pass_start
    logic pop;          // pop top of stack
    logic top_ld;       // reload cached top from stack memory
    logic push;         // write bound, push element, advance
    logic set_computed; // bounds valid
    logic scan_start;   // clear sum, index to zero
    logic scan_issue;   // issue one scan read
    logic out_ld;       // present the sum
  } cmd_t;

  typedef struct packed {
    logic computed;
    logic n_zero;
    logic dir;
    logic do_pop;
    logic last_i;
    logic scan_done;
    logic pipe_empty;
    logic out_free;
  } sts_t;

endpackage

@@ rtl/core/smcq_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smcq_in_if / smcq_out_if: valid/ready channels of the query block
// Input beats carry load or query items, output beats carry counts.
// ----------------------------------------------------------------------------
interface smcq_in_if;
  logic                             valid;
  logic                             ready;
  logic                             mode;
  logic signed [smcq_pkg::VAL_W-1:0] value;
  logic                             last;

  modport source (output valid, mode, value, last, input ready);
  modport sink   (input valid, mode, value, last, output ready);
endinterface

interface smcq_out_if;
  logic                      valid;
  logic                      ready;
  logic [smcq_pkg::SUM_W-1:0] subarray_count;

  modport source (output valid, subarray_count, input ready);
  modport sink   (input valid, subarray_count, output ready);
endinterface

@@ rtl/core/subarray_max_count_query.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// subarray_max_count_query: count of subarrays whose maximum is a given value
// Loads signed elements, finds left/right bounds with a monotonic stack,
// answers per-value subarray counts.
// ----------------------------------------------------------------------------
//  channel  dir  beat contents                     beats out
//  in_i     in   mode, value, last                 -
//  out_o    out  subarray_count                    one per query beat
//
// Load beat: stored as it is accepted. A load with last runs both stack
// passes, each element through FETCH and CHECK and each pop through TOP,
// paced by the sequencer states. Query: a pending bound computation first,
// then a scan over the element and bound memories (one entry per cycle).
// Reset clears counters, flags and FSM only; memories need no clearing.
// The result sits in an output register; input waits only while busy.
// ----------------------------------------------------------------------------
module subarray_max_count_query (
  input  logic clk_i,
  input  logic rst_ni,
  smcq_in_if.sink    in_i,
  smcq_out_if.source out_o
);

  smcq_pkg::cmd_t cmd;
  smcq_pkg::sts_t sts;

  // sequencer: owns input ready and all command timing
  smcq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_mode_i  (in_i.mode),
    .in_last_i  (in_i.last),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // storage, stack and scan arithmetic
  smcq_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_value_i  (in_i.value),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_count_o (out_o.subarray_count)
  );

endmodule

@@ rtl/core/smcq_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smcq_ctrl: sequencer for the query block
// Runs the load, the two monotonic stack passes and the query scan.
// ----------------------------------------------------------------------------
module smcq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_mode_i,
  input  logic              in_last_i,
  output logic              in_ready_o,
  input  smcq_pkg::sts_t    sts_i,
  output smcq_pkg::cmd_t    cmd_o
);

  smcq_pkg::state_e state_q, state_d;
  logic             qpend_q, qpend_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= smcq_pkg::ST_IDLE;
      qpend_q <= 1'b0;
    end else begin
      state_q <= state_d;
      qpend_q <= qpend_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    qpend_d    = qpend_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      smcq_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_mode_i == smcq_pkg::MODE_LOAD) begin
            cmd_o.load = 1'b1;
            qpend_d    = 1'b0;
            if (in_last_i) state_d = smcq_pkg::ST_INIT_L;
          end else begin
            cmd_o.capture_q = 1'b1;
            qpend_d         = 1'b1;
            state_d = sts_i.computed ? smcq_pkg::ST_SCAN_INIT : smcq_pkg::ST_INIT_L;
          end
        end
      end
      smcq_pkg::ST_INIT_L, smcq_pkg::ST_INIT_R: begin
        cmd_o.pass_start = 1'b1;
        cmd_o.pass_dir   = (state_q == smcq_pkg::ST_INIT_R) ? smcq_pkg::DIR_RIGHT
                                                             : smcq_pkg::DIR_LEFT;
        if (sts_i.n_zero) begin
          cmd_o.set_computed = 1'b1;
          state_d = qpend_q ? smcq_pkg::ST_SCAN_INIT : smcq_pkg::ST_IDLE;
        end else begin
          state_d = smcq_pkg::ST_FETCH;
        end
      end
      smcq_pkg::ST_FETCH: state_d = smcq_pkg::ST_CHECK;
      smcq_pkg::ST_CHECK: begin
        if (sts_i.do_pop) begin
          cmd_o.pop = 1'b1;
          state_d   = smcq_pkg::ST_TOP;
        end else begin
          cmd_o.push = 1'b1;
          if (!sts_i.last_i) begin
            state_d = smcq_pkg::ST_FETCH;
          end else if (sts_i.dir == smcq_pkg::DIR_LEFT) begin
            state_d = smcq_pkg::ST_INIT_R;
          end else begin
            cmd_o.set_computed = 1'b1;
            state_d = qpend_q ? smcq_pkg::ST_SCAN_INIT : smcq_pkg::ST_IDLE;
          end
        end
      end
      smcq_pkg::ST_TOP: begin
        cmd_o.top_ld = 1'b1;
        state_d      = smcq_pkg::ST_CHECK;
      end
      smcq_pkg::ST_SCAN_INIT: begin
        cmd_o.scan_start = 1'b1;
        state_d          = smcq_pkg::ST_SCAN;
      end
      smcq_pkg::ST_SCAN: begin
        if (sts_i.scan_done) state_d = smcq_pkg::ST_DRAIN;
        else cmd_o.scan_issue = 1'b1;
      end
      smcq_pkg::ST_DRAIN: begin
        if (sts_i.pipe_empty) state_d = smcq_pkg::ST_OUT;
      end
      smcq_pkg::ST_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_ld = 1'b1;
          qpend_d      = 1'b0;
          state_d      = smcq_pkg::ST_IDLE;
        end
      end
      default: state_d = smcq_pkg::ST_IDLE;
    endcase
  end

endmodule

@@ rtl/core/smcq_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smcq_dp: datapath of the query block
// Element, bound and stack memories, stack pointer, scan pipeline, output.
// ----------------------------------------------------------------------------
module smcq_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  smcq_pkg::cmd_t                    cmd_i,
  output smcq_pkg::sts_t                    sts_o,
  input  logic signed [smcq_pkg::VAL_W-1:0] in_value_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic [smcq_pkg::SUM_W-1:0]        out_count_o
);

  localparam int IW = smcq_pkg::IDX_W;
  localparam int CW = smcq_pkg::CNT_W;
  localparam int VW = smcq_pkg::VAL_W;
  localparam int SW = smcq_pkg::SUM_W;
  localparam int PW = smcq_pkg::PROD_W;
  localparam int AW = smcq_pkg::ACC_W;

  // memories
  logic [VW-1:0]    elem_mem  [smcq_pkg::MAX_ELEMS];
  logic [CW-1:0]    left_mem  [smcq_pkg::MAX_ELEMS];
  logic [CW-1:0]    right_mem [smcq_pkg::MAX_ELEMS];
  logic [IW+VW-1:0] stack_mem [smcq_pkg::MAX_ELEMS];

  logic [VW-1:0]    elem_rd_q;
  logic [CW-1:0]    left_rd_q, right_rd_q;
  logic [IW+VW-1:0] stack_rd_q;

  logic [CW-1:0]    count_q, i_q, sp_q;
  logic             computed_q, dir_q;
  logic [IW-1:0]    top_idx_q;
  logic [VW-1:0]    top_val_q, qval_q;
  logic             s1_v_q, s2_v_q;
  logic [CW-1:0]    s1_idx_q;
  logic [PW-1:0]    prod_q;
  logic [SW-1:0]    sum_q;
  logic             out_valid_q;
  logic [SW-1:0]    out_count_q;

  logic [CW-1:0]    wr_cnt;
  logic             wr_ok;
  logic [CW-1:0]    bound;
  logic [IW-1:0]    stack_rd_addr;
  logic [CW-1:0]    r_len, l_len;
  logic             match;
  logic [AW-1:0]    acc;

  assign wr_cnt        = computed_q ? '0 : count_q;
  assign wr_ok         = wr_cnt < CW'(smcq_pkg::MAX_ELEMS);
  assign stack_rd_addr = IW'(sp_q - CW'(2));
  assign bound = (sp_q != '0) ? {1'b0, top_idx_q}
               : ((dir_q == smcq_pkg::DIR_LEFT) ? '1 : count_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && wr_ok) elem_mem[wr_cnt[IW-1:0]] <= in_value_i;
    if (cmd_i.push && dir_q == smcq_pkg::DIR_LEFT)  left_mem[i_q[IW-1:0]]  <= bound;
    if (cmd_i.push && dir_q == smcq_pkg::DIR_RIGHT) right_mem[i_q[IW-1:0]] <= bound;
    if (cmd_i.push) stack_mem[sp_q[IW-1:0]] <= {i_q[IW-1:0], elem_rd_q};
    elem_rd_q  <= elem_mem[i_q[IW-1:0]];
    left_rd_q  <= left_mem[i_q[IW-1:0]];
    right_rd_q <= right_mem[i_q[IW-1:0]];
    stack_rd_q <= stack_mem[stack_rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      computed_q  <= 1'b0;
      i_q         <= '0;
      sp_q        <= '0;
      dir_q       <= smcq_pkg::DIR_LEFT;
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        count_q    <= wr_cnt + CW'(wr_ok);
        computed_q <= 1'b0;
      end
      if (cmd_i.set_computed) computed_q <= 1'b1;
      if (cmd_i.pass_start) begin
        dir_q <= cmd_i.pass_dir;
        sp_q  <= '0;
        i_q   <= (cmd_i.pass_dir == smcq_pkg::DIR_LEFT) ? '0 : count_q - CW'(1);
      end
      if (cmd_i.pop) sp_q <= sp_q - CW'(1);
      if (cmd_i.push) begin
        sp_q <= sp_q + CW'(1);
        i_q  <= (dir_q == smcq_pkg::DIR_LEFT) ? i_q + CW'(1) : i_q - CW'(1);
      end
      if (cmd_i.scan_start) i_q <= '0;
      if (cmd_i.scan_issue) i_q <= i_q + CW'(1);
      s1_v_q <= cmd_i.scan_issue;
      s2_v_q <= s1_v_q;
      if (cmd_i.out_ld) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // cached top of stack and scan payload
  assign r_len = right_rd_q - s1_idx_q;
  assign l_len = s1_idx_q - left_rd_q;
  assign match = (elem_rd_q == qval_q);
  assign acc   = AW'(sum_q) + AW'(prod_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      top_idx_q <= i_q[IW-1:0];
      top_val_q <= elem_rd_q;
    end
    if (cmd_i.top_ld) {top_idx_q, top_val_q} <= stack_rd_q;
    if (cmd_i.capture_q) qval_q <= in_value_i;
    s1_idx_q <= i_q;
    prod_q   <= match ? r_len * l_len : '0;
    if (cmd_i.scan_start) sum_q <= '0;
    else if (s2_v_q) sum_q <= (acc > AW'(smcq_pkg::SUM_MAX)) ? smcq_pkg::SUM_MAX : acc[SW-1:0];
    if (cmd_i.out_ld) out_count_q <= sum_q;
  end

  always_comb begin
    sts_o.computed   = computed_q;
    sts_o.n_zero     = (count_q == '0);
    sts_o.dir        = dir_q;
    sts_o.do_pop     = (sp_q != '0) &&
                       ((dir_q == smcq_pkg::DIR_LEFT)
                          ? ($signed(elem_rd_q) >= $signed(top_val_q))
                          : ($signed(elem_rd_q) >  $signed(top_val_q)));
    sts_o.last_i     = (dir_q == smcq_pkg::DIR_LEFT) ? (i_q == count_q - CW'(1))
                                                      : (i_q == '0);
    sts_o.scan_done  = (i_q == count_q);
    sts_o.pipe_empty = !s1_v_q && !s2_v_q;
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_count_o = out_count_q;

  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(smcq_pkg::MAX_ELEMS)) else $error("element count above capacity");
  a_sp_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= CW'(smcq_pkg::MAX_ELEMS)) else $error("stack deeper than capacity");
  a_scan_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_v_q |-> $past(s1_v_q)) else $error("scan stage two without stage one");

endmodule
